[hw/rtl/ggpt_pkg.sv]
// Shared types, sizes and constants of the greedy grid path tracer.
`timescale 1ns / 1ps

package ggpt_pkg;

  localparam int ROWS       = 64;
  localparam int COLS       = 64;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int GRID_DEPTH = 1 << ADDR_W;
  localparam int CELL_W     = 16;
  localparam int SCORE_W    = 32;

  // 1/1.414 in Q0.16
  localparam logic [15:0] INV_DIAG = 16'd46348;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRACE = 1'b1;

  localparam logic [1:0] CAND_UP   = 2'd0;
  localparam logic [1:0] CAND_SAME = 2'd1;
  localparam logic [1:0] CAND_DOWN = 2'd2;

  typedef struct packed {
    logic        action;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] cell_value;
  } item_t;

  typedef struct packed {
    logic [5:0]  path_row;
    logic [5:0]  path_col;
    logic [31:0] path_value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       rd_cur;
    logic       cap_cur;
    logic       emit_start;
    logic       issue;
    logic       clear_best;
    logic [1:0] cand;
    logic       emit_step;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic trace_ok;
    logic pipe_busy;
    logic out_free;
    logic last_step;
  } stat_t;

endpackage

[hw/rtl/ggpt_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module ggpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/ggpt_dpath.sv]
// Datapath: grid store, score pipeline, best-candidate tracking, result register.
`timescale 1ns / 1ps

module ggpt_dpath (
  input  logic            clk,
  input  logic            rst,
  input  ggpt_pkg::item_t item,
  input  ggpt_pkg::cmd_t  cmd,
  output ggpt_pkg::stat_t stat,
  output logic            result_valid,
  input  logic            result_stall,
  output ggpt_pkg::result_t result
);
  import ggpt_pkg::*;

  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [CELL_W-1:0] cur;

  logic              we, re;
  logic [ADDR_W-1:0] addr;
  logic [CELL_W-1:0] rdata;
  logic              load_ok;

  logic [ROW_W-1:0] cand_row;
  logic             cand_ok;
  logic             cand_diag;
  logic [COL_W-1:0] c_step;

  logic               v1, v2, v3;
  logic               diag1, diag2;
  logic [ROW_W-1:0]   nr1, nr2, nr3;
  logic [CELL_W-1:0]  cell2, cell3;
  logic [SCORE_W-1:0] prod2, score3;
  logic [47:0]        scaled;

  logic               have;
  logic [SCORE_W-1:0] best_score;
  logic [ROW_W-1:0]   best_row;
  logic [CELL_W-1:0]  best_cell;

  assign c_step  = c + 1'b1;
  assign load_ok = (32'(item.row) < ROWS) && (32'(item.col) < COLS);

  always_comb begin
    cand_row  = r;
    cand_ok   = 1'b1;
    cand_diag = 1'b0;
    case (cmd.cand)
      CAND_UP: begin
        cand_row  = r - 1'b1;
        cand_ok   = (r != '0);
        cand_diag = 1'b1;
      end
      CAND_DOWN: begin
        cand_row  = r + 1'b1;
        cand_ok   = (r != ROW_W'(ROWS - 1));
        cand_diag = 1'b1;
      end
      default: begin
        cand_row  = r;
        cand_ok   = 1'b1;
        cand_diag = 1'b0;
      end
    endcase
  end

  always_comb begin
    we   = cmd.load && load_ok;
    re   = cmd.rd_cur || cmd.issue;
    addr = {cand_row, c_step};
    if (cmd.load) begin
      addr = {ROW_W'(item.row), COL_W'(item.col)};
    end else if (cmd.rd_cur) begin
      addr = {r, c};
    end
  end

  ggpt_ram #(
    .WIDTH(CELL_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (we),
    .re   (re),
    .addr (addr),
    .wdata(item.cell_value),
    .rdata(rdata)
  );

  assign scaled = 48'(prod2) * 48'(INV_DIAG);

  // score pipeline: read, multiply, diagonal scale, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      have <= 1'b0;
    end else begin
      v1 <= cmd.issue && cand_ok;
      v2 <= v1;
      v3 <= v2;
      if (cmd.clear_best) begin
        have <= 1'b0;
      end else if (v3 && (!have || score3 > best_score)) begin
        have <= 1'b1;
      end
    end
    diag1 <= cand_diag;
    nr1   <= cand_row;
    prod2 <= 32'(cur) * 32'(rdata);
    cell2 <= rdata;
    diag2 <= diag1;
    nr2   <= nr1;
    score3 <= diag2 ? scaled[47:16] : prod2;
    cell3  <= cell2;
    nr3    <= nr2;
    if (v3 && (!have || score3 > best_score)) begin
      best_score <= score3;
      best_row   <= nr3;
      best_cell  <= cell3;
    end
  end

  // trace position and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.start) begin
      r <= ROW_W'(item.row);
      c <= '0;
    end
    if (cmd.cap_cur) begin
      cur <= rdata;
    end
    if (cmd.emit_start) begin
      result.path_row   <= 6'(r);
      result.path_col   <= 6'(c);
      result.path_value <= SCORE_W'(cur) << 8;
      result.last       <= 1'b0;
    end
    if (cmd.emit_step) begin
      r   <= best_row;
      c   <= c_step;
      cur <= best_cell;
      result.path_row   <= 6'(best_row);
      result.path_col   <= 6'(c_step);
      result.path_value <= best_score;
      result.last       <= stat.last_step;
    end
  end

  assign stat.is_load   = (item.action == ACT_LOAD);
  assign stat.trace_ok  = (32'(item.row) < ROWS);
  assign stat.pipe_busy = v1 || v2 || v3;
  assign stat.out_free  = !result_valid || !result_stall;
  assign stat.last_step = (c == COL_W'(COLS - 2));

endmodule

[hw/rtl/ggpt_ctrl.sv]
// Controller: sequences loads, the start node and the column steps of a trace.
`timescale 1ns / 1ps

module ggpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  ggpt_pkg::stat_t stat,
  output ggpt_pkg::cmd_t  cmd
);
  import ggpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_LD0,
    S_EMIT0,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [1:0] cand, cand_next;
  logic       accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd        = '0;
    cmd.cand   = cand;
    state_next = state;
    cand_next  = cand;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.is_load) begin
            cmd.load = 1'b1;
          end else if (stat.trace_ok) begin
            cmd.start  = 1'b1;
            state_next = S_RD0;
          end
        end
      end
      S_RD0: begin
        cmd.rd_cur = 1'b1;
        state_next = S_LD0;
      end
      S_LD0: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_EMIT0;
      end
      S_EMIT0: begin
        if (stat.out_free) begin
          cmd.emit_start = 1'b1;
          cand_next      = CAND_UP;
          state_next     = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue      = 1'b1;
        cmd.clear_best = (cand == CAND_UP);
        cand_next      = cand + 1'b1;
        if (cand == CAND_DOWN) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          cand_next     = CAND_UP;
          state_next    = stat.last_step ? S_IDLE : S_ISSUE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cand  <= CAND_UP;
    end else begin
      state <= state_next;
      cand  <= cand_next;
    end
  end

endmodule

[hw/rtl/greedy_grid_path_trace.sv]
// Top level of the greedy grid path tracer.
`timescale 1ns / 1ps

// Load beats write one Q8.8 cell into the grid store; the
// store is not cleared at reset, so every cell must be loaded before a trace
// reads it. A trace beat returns COLS result beats: the start cell at column 0
// with its value in Q16.16, then one node per column chosen as the first best
// of up to three neighbors, with last set on the final column. A trace holds
// the input stalled until its last node is emitted: each column reads
// its three candidates from the single-port grid memory one per cycle, and
// each read runs through a product stage, a diagonal scaling stage and a
// compare before the node is emitted.
module greedy_grid_path_trace (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ggpt_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ggpt_pkg::result_t result
);
  import ggpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ggpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ggpt_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

[sim/greedy_grid_path_trace_test.sv]
// Self-checking testbench for the greedy grid path tracer: grid loads, traces, random stalls.
`timescale 1ns / 1ps

module greedy_grid_path_trace_test;
  import ggpt_pkg::*;

  localparam int RANDOM_ITEMS   = 50;
  localparam int IDLE_PCT       = 23;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int STEADY_FROM    = 15;
  localparam int STEADY_TO      = 35;

  // Traces stay in two bands: rows 0..2 free, row 3 held at zero so a path
  // never steps onto it; the bottom row held nonzero under a zero row.
  localparam int TOP_BAR = 3;
  localparam int BOT_BAR = ROWS - 2;
  localparam int BOT_ROW = ROWS - 1;

  // Predicts every path node from its own copy of the grid.
  class path_scoreboard;
    logic [CELL_W-1:0] grid [ROWS*COLS];
    logic [ROW_W-1:0]  tail_row;
    logic [COL_W-1:0]  tail_col;
    result_t           node_q[$];
    int n_errors;
    int n_checked;
    int n_loads;
    int n_traces;
    int n_ties;

    function new();
      tail_row  = '0;
      tail_col  = '0;
      n_errors  = 0;
      n_checked = 0;
      n_loads   = 0;
      n_traces  = 0;
      n_ties    = 0;
    endfunction

    function int pending();
      return node_q.size();
    endfunction

    function void note_item(item_t it);
      int r;
      int best_row;
      logic [CELL_W-1:0] cur;
      logic [63:0] s;
      logic [SCORE_W-1:0] best;
      bit have;
      result_t node;
      if (it.action == ACT_LOAD) begin
        if (it.row < ROWS && it.col < COLS) grid[it.row*COLS + it.col] = it.cell_value;
        n_loads++;
        return;
      end
      if (it.row >= ROWS) return;
      n_traces++;
      r = int'(it.row);
      node.path_row   = ROW_W'(r);
      node.path_col   = '0;
      node.path_value = SCORE_W'(grid[r*COLS]) << 8;
      node.last       = (COLS <= 1);
      node_q = {node_q, node};
      for (int c = 0; c + 1 < COLS; c++) begin
        cur      = grid[r*COLS + c];
        have     = 0;
        best     = '0;
        best_row = 0;
        for (int d = -1; d <= 1; d++) begin
          if (r + d < 0 || r + d >= ROWS) continue;
          s = 64'(cur) * 64'(grid[(r+d)*COLS + c + 1]);
          if (d != 0) s = (s * 64'(INV_DIAG)) >> 16;
          if (have && s[31:0] == best) n_ties++;
          if (!have || s[31:0] > best) begin
            have     = 1;
            best     = s[31:0];
            best_row = r + d;
          end
        end
        r = best_row;
        node.path_row   = ROW_W'(r);
        node.path_col   = COL_W'(c + 1);
        node.path_value = best;
        node.last       = (c + 2 >= COLS);
        node_q = {node_q, node};
      end
      tail_row = ROW_W'(r);
      tail_col = COL_W'(COLS - 1);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      n_checked++;
      if (node_q.size() == 0) begin
        $display("%0t: unexpected node row %0d col %0d value %h last %0d", $time,
                 got.path_row, got.path_col, got.path_value, got.last);
        n_errors++;
        return;
      end
      exp = node_q.pop_front();
      if (got.path_row !== exp.path_row || got.path_col !== exp.path_col ||
          got.path_value !== exp.path_value || got.last !== exp.last) begin
        $display("%0t: node mismatch expected row %0d col %0d value %h last %0d",
                 $time, exp.path_row, exp.path_col, exp.path_value, exp.last);
        $display("%0t:                actual row %0d col %0d value %h last %0d",
                 $time, got.path_row, got.path_col, got.path_value, got.last);
        n_errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  bit      steady = 1'b0;
  int      quiet_cycles = 0;

  path_scoreboard sb = new();

  greedy_grid_path_trace u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic item_t make_item(logic act, logic [5:0] r, logic [5:0] c,
                                      logic [15:0] v);
    item_t it;
    it.action     = act;
    it.row        = r;
    it.col        = c;
    it.cell_value = v;
    return it;
  endfunction

  // Skewed toward zero, full scale and tiny values so ties turn up often.
  function automatic logic [15:0] cell_pick();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      3: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] band_value(logic [5:0] r);
    logic [15:0] v;
    v = cell_pick();
    if (r == 6'(TOP_BAR) || r == 6'(BOT_BAR)) return 16'h0000;
    if (r == 6'(BOT_ROW) && v == 16'h0000) return 16'h0001;
    return v;
  endfunction

  // rows between the bands are never read, so any value goes there
  function automatic logic [5:0] load_row();
    case ($urandom_range(0, 5))
      0: return 6'(TOP_BAR);
      1: return 6'(BOT_BAR);
      2: return 6'(BOT_ROW);
      3: return 6'($urandom);
      default: return 6'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [5:0] trace_row();
    case ($urandom_range(0, 3))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      default: return 6'(BOT_ROW);
    endcase
  endfunction

  task automatic send_beat(item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // Receiver: random stalls plus one long hold-off so the block backs up.
  initial begin : result_side
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 0;
    forever begin
      @(negedge clk);
      if (!held && sb.n_checked >= HOLD_AFTER) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [5:0] row_pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every cell a trace can reach is written first
    for (int r = 0; r <= TOP_BAR; r++)
      for (int c = 0; c < COLS; c++)
        send_beat(make_item(ACT_LOAD, 6'(r), 6'(c), band_value(6'(r))));
    for (int r = BOT_BAR; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        send_beat(make_item(ACT_LOAD, 6'(r), 6'(c), band_value(6'(r))));

    // full-scale products along the top edge
    send_beat(make_item(ACT_LOAD, 0, 0, 16'hFFFF));
    send_beat(make_item(ACT_LOAD, 0, 1, 16'hFFFF));
    send_beat(make_item(ACT_LOAD, 1, 1, 16'hFFFF));
    send_beat(make_item(ACT_TRACE, 0, 6'h3F, 16'hFFFF));
    // zero start cell: all scores zero, first row wins
    send_beat(make_item(ACT_LOAD, 1, 0, 16'h0000));
    send_beat(make_item(ACT_TRACE, 1, 0, 16'h0000));
    // flat neighborhood: straight step beats the scaled diagonals
    send_beat(make_item(ACT_LOAD, 1, 0, 16'h0100));
    send_beat(make_item(ACT_LOAD, 0, 1, 16'h0100));
    send_beat(make_item(ACT_LOAD, 1, 1, 16'h0100));
    send_beat(make_item(ACT_LOAD, 2, 1, 16'h0100));
    send_beat(make_item(ACT_TRACE, 1, 6'h2A, 16'h5555));
    // equal diagonals: the upper one wins
    send_beat(make_item(ACT_LOAD, 1, 0, 16'h0100));
    send_beat(make_item(ACT_LOAD, 0, 1, 16'h0200));
    send_beat(make_item(ACT_LOAD, 1, 1, 16'h0000));
    send_beat(make_item(ACT_LOAD, 2, 1, 16'h0200));
    send_beat(make_item(ACT_TRACE, 1, 6'h15, 16'hAAAA));
    // bottom edge: no lower neighbor
    send_beat(make_item(ACT_TRACE, 6'(BOT_ROW), 0, 16'h0000));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= STEADY_FROM && i < STEADY_TO);
      if ($urandom_range(0, 9) < 4) begin
        row_pick = load_row();
        send_beat(make_item(ACT_LOAD, row_pick, 6'($urandom), band_value(row_pick)));
      end else begin
        send_beat(make_item(ACT_TRACE, trace_row(), 6'($urandom), 16'($urandom)));
      end
    end
    steady = 1'b0;
    @(negedge clk);
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d grid loads and %0d traces; %0d path nodes checked,",
             sb.n_loads, sb.n_traces, sb.n_checked);
    $display("%0d candidate comparisons ended in a tie, one long output hold-off.",
             sb.n_ties);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ggpt_pkg.sv
hw/rtl/ggpt_ram.sv
hw/rtl/ggpt_dpath.sv
hw/rtl/ggpt_ctrl.sv
hw/rtl/greedy_grid_path_trace.sv
sim/greedy_grid_path_trace_test.sv
